// ===== design/battery_uvlo_monitor_assert.svh =====
// assertion macros for the battery undervoltage lockout monitor
`ifndef BATTERY_UVLO_MONITOR_ASSERT_SVH
`define BATTERY_UVLO_MONITOR_ASSERT_SVH

// same-cycle implication, checked on every rising edge out of reset
`define BUM_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bum: same-cycle check failed");

// next-cycle implication
`define BUM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bum: next-cycle check failed");

`endif

// ===== design/bum_pkg.sv =====
// shared types, codes and fixed-point constants of the battery monitor
package bum_pkg;

	// fixed-point layout of the filter: whole millivolts then fraction bits
	localparam int FRACTION_BITS = 8;
	localparam int FILT_W        = 16 + FRACTION_BITS;
	localparam int PIN_W         = 12;
	localparam int SCALE_W       = 13;
	localparam int PROD_W        = PIN_W + SCALE_W;
	localparam int MEAS_EXT_W    = PROD_W + FRACTION_BITS;
	localparam int ACC_W         = FILT_W + 9;
	localparam int THR_W         = 16;
	localparam int CFG_W         = 16;
	localparam int CFG_IDX_W     = 3;

	// ema weights, alpha 38/256
	localparam int ALPHA_NUM  = 38;
	localparam int ALPHA_REST = 218;
	localparam int ROUND_HALF = 128;

	localparam logic [FILT_W-1:0] FILT_MAX     = {FILT_W{1'b1}};
	localparam logic [FILT_W-1:0] FILT_100MV   = FILT_W'(100) << FRACTION_BITS;
	localparam logic [FILT_W-1:0] FILT_4000MV  = FILT_W'(4000) << FRACTION_BITS;
	localparam logic [FILT_W-1:0] FILT_5500MV  = FILT_W'(5500) << FRACTION_BITS;
	localparam logic [FILT_W-1:0] FILT_8800MV  = FILT_W'(8800) << FRACTION_BITS;
	localparam logic [FILT_W-1:0] FILT_13000MV = FILT_W'(13000) << FRACTION_BITS;

	// register reset values
	localparam logic [12:0] SCALE_RST      = 13'd2816;
	localparam logic [12:0] WARN_RST       = 13'd3500;
	localparam logic [12:0] CUTOFF_RST     = 13'd3300;
	localparam logic [15:0] SAG_RST        = 16'd500;
	localparam logic [9:0]  PERIOD_RST     = 10'd50;
	localparam logic        BUCK_START_RST = 1'b1;

	typedef enum logic [2:0] {
		CMD_UPDATE = 3'd0,
		CMD_PRIME  = 3'd1,
		CMD_DETECT = 3'd2,
		CMD_CLEAR  = 3'd3,
		CMD_BUCK   = 3'd4
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SCALE      = 3'd0,
		CFG_WARN       = 3'd1,
		CFG_CUTOFF     = 3'd2,
		CFG_SAG        = 3'd3,
		CFG_PERIOD     = 3'd4,
		CFG_BUCK_START = 3'd5
	} cfg_idx_t;

	typedef enum logic [1:0] {
		STAT_UNKNOWN  = 2'd0,
		STAT_HEALTHY  = 2'd1,
		STAT_LOW      = 2'd2,
		STAT_CRITICAL = 2'd3
	} stat_t;

	// controller to datapath strobes
	typedef struct packed {
		logic ld_in;
		logic mul;
		logic ema_a;
		logic ema_b;
		logic detect;
		logic eval;
		logic act;
		logic load_out;
	} dp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic is_update;
		logic is_prime;
		logic is_detect;
		logic is_act;
		logic rate_ok;
	} dp_status_t;

endpackage

// ===== design/bum_ctrl.sv =====
// sequencing state machine and output handshake of the battery monitor
module bum_ctrl import bum_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t sts,
	output dp_cmd_t    cmd
);

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_CHECK = 9'b000000010,
		ST_MUL   = 9'b000000100,
		ST_EMA1  = 9'b000001000,
		ST_EMA2  = 9'b000010000,
		ST_DET   = 9'b000100000,
		ST_EVAL  = 9'b001000000,
		ST_ACT   = 9'b010000000,
		ST_OUT   = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	// next state and strobes
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.ld_in = in_valid;
				if (in_valid) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (sts.is_update) state_d = sts.rate_ok ? ST_MUL : ST_OUT;
				else if (sts.is_prime) state_d = ST_MUL;
				else if (sts.is_detect) state_d = ST_DET;
				else if (sts.is_act) state_d = ST_ACT;
				else state_d = ST_OUT;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_EMA1;
			end
			ST_EMA1: begin
				cmd.ema_a = 1'b1;
				state_d   = ST_EMA2;
			end
			ST_EMA2: begin
				cmd.ema_b = 1'b1;
				state_d   = sts.is_update ? ST_DET : ST_OUT;
			end
			ST_DET: begin
				cmd.detect = 1'b1;
				state_d    = sts.is_update ? ST_EVAL : ST_OUT;
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = ST_OUT;
			end
			ST_ACT: begin
				cmd.act = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== design/bum_datapath.sv =====
// filter, detection, classification and lockout datapath of the battery monitor
module bum_datapath import bum_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic [2:0]           command,
	input  logic [PIN_W-1:0]     pin_millivolts,
	input  logic [31:0]          now_ms,
	input  logic                 buck_request,
	input  dp_cmd_t              cmd,
	output dp_status_t           sts,
	output logic [1:0]           battery_status,
	output logic [2:0]           cells,
	output logic [15:0]          filtered_mv,
	output logic                 buck_on,
	output logic                 lockout_latched,
	output logic                 lockout_event,
	output logic                 sample_taken
);

	// configuration registers
	logic [SCALE_W-1:0] scale_q;
	logic [12:0]        warn_q;
	logic [12:0]        cutoff_q;
	logic [15:0]        sag_q;
	logic [9:0]         period_q;

	// latched input beat
	logic [2:0]       cmd_q;
	logic [PIN_W-1:0] pin_q;
	logic [31:0]      now_q;
	logic             req_q;

	// arithmetic intermediates
	logic [PROD_W-1:0] prod_q;
	logic [FILT_W-1:0] meas_q;
	logic [ACC_W-1:0]  acc_q;

	// architectural state
	logic [FILT_W-1:0] filt_q;
	logic [2:0]        cells_q;
	stat_t             status_q;
	logic              buck_q;
	logic              trip_q;
	logic [31:0]       last_q;
	logic [31:0]       lstart_q;
	logic              lvalid_q;
	logic              taken_q;
	logic              event_q;

	// result register
	logic [1:0]  res_status_q;
	logic [2:0]  res_cells_q;
	logic [15:0] res_mv_q;
	logic        res_buck_q;
	logic        res_trip_q;
	logic        res_event_q;
	logic        res_taken_q;

	logic [MEAS_EXT_W-1:0] meas_shl;
	logic [MEAS_EXT_W-1:0] meas_full;
	logic [FILT_W-1:0]     meas_sat;
	logic [ACC_W-1:0]      ema_sum;
	logic [FILT_W:0]       ema_v;
	logic [FILT_W-1:0]     ema_sat;
	logic [2:0]            det_cells;
	logic [THR_W-1:0]      warn_thr;
	logic [THR_W-1:0]      cut_thr;
	logic [FILT_W-1:0]     warn_lim;
	logic [FILT_W-1:0]     cut_lim;
	logic [31:0]           since_sample;
	logic [31:0]           since_low;

	// status toward the controller
	always_comb begin
		since_sample  = now_q - last_q;
		sts.is_update = (cmd_q == CMD_UPDATE);
		sts.is_prime  = (cmd_q == CMD_PRIME);
		sts.is_detect = (cmd_q == CMD_DETECT);
		sts.is_act    = (cmd_q == CMD_CLEAR) || (cmd_q == CMD_BUCK);
		sts.rate_ok   = (since_sample >= {22'd0, period_q});
	end

	// measured value moved from 8 fraction bits to the filter format, saturated
	always_comb begin
		meas_shl  = MEAS_EXT_W'(prod_q) << FRACTION_BITS;
		meas_full = meas_shl >> 8;
		meas_sat  = (|meas_full[MEAS_EXT_W-1:FILT_W]) ? FILT_MAX : meas_full[FILT_W-1:0];
	end

	// second half of the ema with rounding and saturation
	always_comb begin
		ema_sum = acc_q + ACC_W'(meas_q) * ACC_W'(ALPHA_NUM) + ACC_W'(ROUND_HALF);
		ema_v   = ema_sum[ACC_W-1:8];
		ema_sat = ema_v[FILT_W] ? FILT_MAX : ema_v[FILT_W-1:0];
	end

	// pack detection from the filter
	always_comb begin
		if (filt_q > FILT_13000MV) det_cells = 3'd4;
		else if (filt_q > FILT_8800MV) det_cells = 3'd3;
		else if (filt_q > FILT_5500MV) det_cells = 3'd2;
		else det_cells = 3'd0;
	end

	// per-pack thresholds in filter format
	always_comb begin
		warn_thr  = THR_W'(warn_q) * THR_W'(cells_q);
		cut_thr   = THR_W'(cutoff_q) * THR_W'(cells_q);
		warn_lim  = {warn_thr, {FRACTION_BITS{1'b0}}};
		cut_lim   = {cut_thr, {FRACTION_BITS{1'b0}}};
		since_low = now_q - lstart_q;
	end

	// configuration writes; buck start level only matters at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q  <= SCALE_RST;
			warn_q   <= WARN_RST;
			cutoff_q <= CUTOFF_RST;
			sag_q    <= SAG_RST;
			period_q <= PERIOD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SCALE:  scale_q  <= cfg_wdata[SCALE_W-1:0];
				CFG_WARN:   warn_q   <= cfg_wdata[12:0];
				CFG_CUTOFF: cutoff_q <= cfg_wdata[12:0];
				CFG_SAG:    sag_q    <= cfg_wdata;
				CFG_PERIOD: period_q <= cfg_wdata[9:0];
				default: ;
			endcase
		end
	end

	// input beat capture and arithmetic pipeline registers
	always_ff @(posedge clk) begin
		if (cmd.ld_in) begin
			cmd_q <= command;
			pin_q <= pin_millivolts;
			now_q <= now_ms;
			req_q <= buck_request;
		end
		if (cmd.mul) prod_q <= PROD_W'(pin_q) * PROD_W'(scale_q);
		if (cmd.ema_a) begin
			meas_q <= meas_sat;
			acc_q  <= ACC_W'(filt_q) * ACC_W'(ALPHA_REST);
		end
	end

	// filter, detection, classification and lockout state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_q   <= '0;
			cells_q  <= 3'd0;
			status_q <= STAT_UNKNOWN;
			buck_q   <= BUCK_START_RST;
			trip_q   <= 1'b0;
			last_q   <= '0;
			lstart_q <= '0;
			lvalid_q <= 1'b0;
			taken_q  <= 1'b0;
			event_q  <= 1'b0;
		end else begin
			if (cmd.ld_in) begin
				taken_q <= 1'b0;
				event_q <= 1'b0;
			end
			if (cmd.ema_b) begin
				filt_q <= (filt_q <= FILT_100MV) ? meas_q : ema_sat;
				if (cmd_q == CMD_UPDATE) begin
					last_q  <= now_q;
					taken_q <= 1'b1;
				end
			end
			if (cmd.detect) begin
				if (cmd_q == CMD_DETECT) cells_q <= det_cells;
				else if (cells_q == 3'd0 && filt_q > FILT_5500MV) cells_q <= det_cells;
			end
			if (cmd.eval) begin
				if (filt_q < FILT_4000MV || cells_q == 3'd0) begin
					status_q <= STAT_UNKNOWN;
				end else if (filt_q >= warn_lim) begin
					status_q <= STAT_HEALTHY;
					lvalid_q <= 1'b0;
				end else if (filt_q > cut_lim) begin
					status_q <= STAT_LOW;
					lvalid_q <= 1'b0;
				end else if (!lvalid_q) begin
					lvalid_q <= 1'b1;
					lstart_q <= now_q;
				end else if (since_low >= {16'd0, sag_q}) begin
					status_q <= STAT_CRITICAL;
					if (buck_q && !trip_q) begin
						trip_q  <= 1'b1;
						buck_q  <= 1'b0;
						event_q <= 1'b1;
					end
				end
			end
			if (cmd.act) begin
				case (cmd_q)
					CMD_CLEAR: begin
						trip_q   <= 1'b0;
						lvalid_q <= 1'b0;
						buck_q   <= 1'b1;
					end
					CMD_BUCK: buck_q <= req_q;
					default: ;
				endcase
			end
		end
	end

	// result beat register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			res_status_q <= status_q;
			res_cells_q  <= cells_q;
			res_mv_q     <= filt_q[FILT_W-1:FRACTION_BITS];
			res_buck_q   <= buck_q;
			res_trip_q   <= trip_q;
			res_event_q  <= event_q;
			res_taken_q  <= taken_q;
		end
	end

	assign battery_status  = res_status_q;
	assign cells           = res_cells_q;
	assign filtered_mv     = res_mv_q;
	assign buck_on         = res_buck_q;
	assign lockout_latched = res_trip_q;
	assign lockout_event   = res_event_q;
	assign sample_taken    = res_taken_q;

endmodule

// ===== design/battery_uvlo_monitor.sv =====
// top level of the battery undervoltage lockout monitor
// One result beat per input beat, one beat in flight at a time. After the input beat is
// taken an accepted update sample runs scale multiply, two ema steps, detection, evaluation
// and result load, a priming sample skips detection and evaluation, detect, UVLO reset and
// set buck run one step and load, and a rate-limited sample or undefined command only load.
// The next beat is taken while the previous result waits downstream; only a second result
// that finds the output register still full holds the sequencer. Filter is kept in
// millivolts with 8 fraction bits; the buck level starts at 1 on reset.
`include "battery_uvlo_monitor_assert.svh"

module battery_uvlo_monitor import bum_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [2:0]           command,
	input  logic [PIN_W-1:0]     pin_millivolts,
	input  logic [31:0]          now_ms,
	input  logic                 buck_request,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [1:0]           battery_status,
	output logic [2:0]           cells,
	output logic [15:0]          filtered_mv,
	output logic                 buck_on,
	output logic                 lockout_latched,
	output logic                 lockout_event,
	output logic                 sample_taken
);

	dp_cmd_t    dp_cmd;
	dp_status_t dp_sts;

	// sequencer
	bum_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (dp_sts),
		.cmd       (dp_cmd)
	);

	// datapath
	bum_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.command         (command),
		.pin_millivolts  (pin_millivolts),
		.now_ms          (now_ms),
		.buck_request    (buck_request),
		.cmd             (dp_cmd),
		.sts             (dp_sts),
		.battery_status  (battery_status),
		.cells           (cells),
		.filtered_mv     (filtered_mv),
		.buck_on         (buck_on),
		.lockout_latched (lockout_latched),
		.lockout_event   (lockout_event),
		.sample_taken    (sample_taken)
	);

	// a taken beat keeps the block busy for at least the following cycle
	`BUM_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
	// a trip beat always shows the latch set and the buck off
	`BUM_ASSERT_NOW(a_event_consistent, out_valid && lockout_event, lockout_latched && !buck_on)
	// the filter is never written while waiting for a beat
	`BUM_ASSERT_NOW(a_no_filter_write_idle, in_ready, !dp_cmd.ema_b && !dp_cmd.eval)

endmodule
